// ----- rtl/core/rvd_pkg.sv -----
// Package for the vector rotation pipeline: formats, constants and elaboration-time tables.
`timescale 1ns / 1ps

package rvd_pkg;

    // Default count of micro-rotation stages.
    localparam int CORDIC_STAGES_DEF = 24;

    // Widths of the item fields.
    localparam int VEC_W   = 32;
    localparam int ANGLE_W = 25;

    // Angle units: Q9.16 degrees.
    localparam int DEG_UNIT = 65536;
    localparam logic [ANGLE_W-1:0] QUARTER_TURN = ANGLE_W'(90 * DEG_UNIT);
    localparam logic [ANGLE_W-1:0] HALF_TURN    = ANGLE_W'(180 * DEG_UNIT);
    localparam logic [ANGLE_W-1:0] THREE_QUARTER_TURN = ANGLE_W'(270 * DEG_UNIT);
    localparam logic [ANGLE_W-1:0] FULL_TURN    = ANGLE_W'(360 * DEG_UNIT);
    localparam int REM_W = 23;

    // Pi with 60 fraction bits and the CORDIC gain with 32 fraction bits.
    localparam logic [63:0] PI_Q60   = 64'h3243_F6A8_885A_308D;
    localparam logic [31:0] GAIN_Q32 = 32'h9B74_EDA8;

    // Radians per angle unit, Q60, split in two halves for the multiply.
    localparam logic [63:0] RAD_PER_UNIT = PI_Q60 / (64'd180 * 64'd65536);
    localparam int RAD_LO_W = 20;
    localparam int RAD_HI_W = 19;
    localparam logic [RAD_LO_W-1:0] RAD_LO = RAD_PER_UNIT[RAD_LO_W-1:0];
    localparam logic [RAD_HI_W-1:0] RAD_HI = RAD_PER_UNIT[RAD_LO_W+RAD_HI_W-1:RAD_LO_W];

    // Datapath widths: gained vector, rotating vector and residual angle.
    localparam int GX_W = 48;
    localparam int XW   = 50;
    localparam int ZW   = 62;

    // Quarter turn applied before the micro-rotations.
    typedef enum logic [1:0] {
        QT_0,
        QT_90,
        QT_180,
        QT_270
    } quad_t;

    // Long division of a constant by a small divisor, for elaboration only.
    function automatic logic [63:0] div_const(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] r;
        logic [63:0] q;
        r = '0;
        q = '0;
        for (int b = 63; b >= 0; b--)
        begin
            r = {r[62:0], num[b]};
            if (r >= den)
            begin
                r = r - den;
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // Arctangent of 2^-i with 60 fraction bits, from its series (pi/4 for i = 0).
    function automatic logic [63:0] atan_q60(input int i);
        logic signed [63:0] sum;
        logic [63:0] term;
        int e;
        sum = '0;
        if (i == 0)
        begin
            sum = $signed(PI_Q60 >> 2);
        end
        else
        begin
            for (int k = 0; k < 31; k++)
            begin
                e = i * (2 * k + 1);
                if (e <= 60)
                begin
                    term = div_const(64'd1 << (60 - e), 64'(2 * k + 1));
                    if (k % 2 == 1)
                        sum = sum - $signed(term);
                    else
                        sum = sum + $signed(term);
                end
            end
        end
        return sum;
    endfunction

    // Round to Q16.16 (half up) and saturate to 32 bits.
    function automatic logic [VEC_W-1:0] round_sat(input logic signed [XW-1:0] v);
        logic signed [XW:0]    s;
        logic signed [XW-16:0] r;
        s = $signed({v[XW-1], v}) + $signed({{(XW-15){1'b0}}, 1'b1, 15'd0});
        r = s[XW:16];
        if (r > $signed({{(XW-46){1'b0}}, 31'h7FFF_FFFF}))
            return 32'h7FFF_FFFF;
        else if (r < $signed({{(XW-46){1'b1}}, 31'h0}))
            return 32'h8000_0000;
        else
            return r[VEC_W-1:0];
    endfunction

endpackage

// ----- rtl/core/rotate_vector_degrees.sv -----
// Pipelined CORDIC rotation of a Q16.16 vector clockwise by an angle in degrees.
`timescale 1ns / 1ps

// Accepts one word per cycle while not stalled and returns one rotated word per input, in
// order, through these register stages: one for angle reduction and the quarter turn, one
// for the gain multiply and the angle-to-radian partial products, one that sums the radian
// angle, one stage per micro-rotation, and an output stage that rounds to Q16.16 and
// saturates. Every stage holds its own valid bit, so bubbles close up under output
// back-pressure and input is refused only when every stage is full. The angle must be
// below 360 degrees; larger codes are reduced once.
module rotate_vector_degrees
    import rvd_pkg::*;
#(
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [31:0] vec_x, [63:32] vec_y, [88:64] angle_deg, [95:89] zero
    input  logic [95:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [31:0] rot_x, [63:32] rot_y
    output logic [63:0] m_tdata
);

    localparam int L = CORDIC_STAGES + 4;

    logic [L-1:0] vld_reg;
    logic [L-1:0] rdy;

    // Stage 0: reduction and quarter turn.
    logic [ANGLE_W-1:0]     ang_red;
    quad_t                  quad;
    logic [ANGLE_W-1:0]     ang_off;
    logic signed [VEC_W:0]  in_x;
    logic signed [VEC_W:0]  in_y;
    logic signed [VEC_W:0]  qx_next;
    logic signed [VEC_W:0]  qy_next;
    logic signed [VEC_W:0]  qx_reg;
    logic signed [VEC_W:0]  qy_reg;
    logic [ANGLE_W-1:0]     rem_full;
    logic [REM_W-1:0]       rem_reg;

    // Stage 1: gain and radian partial products.
    logic signed [65:0]             px;
    logic signed [65:0]             py;
    logic signed [GX_W-1:0]         gx_reg;
    logic signed [GX_W-1:0]         gy_reg;
    logic [REM_W+RAD_HI_W-1:0]      zhi_next;
    logic [REM_W+RAD_LO_W-1:0]      zlo_next;
    logic [REM_W+RAD_HI_W-1:0]      zhi_reg;
    logic [REM_W+RAD_LO_W-1:0]      zlo_reg;

    // Stage 2 onwards: rotating vector and residual angle.
    logic signed [XW-1:0] cx_reg [CORDIC_STAGES+1];
    logic signed [XW-1:0] cy_reg [CORDIC_STAGES+1];
    logic signed [ZW-1:0] cz_reg [CORDIC_STAGES+1];

    // Output stage.
    logic [VEC_W-1:0] rx_reg;
    logic [VEC_W-1:0] ry_reg;

    // A stage may load when it is empty or its word moves on in the same cycle.
    always_comb
    begin
        rdy[L-1] = !vld_reg[L-1] || m_tready;
        for (int s = L - 2; s >= 0; s--)
            rdy[s] = !vld_reg[s] || rdy[s+1];
    end

    assign s_tready = rdy[0];
    assign m_tvalid = vld_reg[L-1];
    assign m_tdata  = {ry_reg, rx_reg};

    // Valid bits travel with the data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (rdy[0])
                vld_reg[0] <= s_tvalid;
            for (int s = 1; s < L; s++)
            begin
                if (rdy[s])
                    vld_reg[s] <= vld_reg[s-1];
            end
        end
    end

    // Angle reduction and quarter-turn decode.
    always_comb
    begin
        ang_red = (s_tdata[88:64] >= FULL_TURN) ? s_tdata[88:64] - FULL_TURN
                                                 : s_tdata[88:64];
        if (ang_red < QUARTER_TURN)
            quad = QT_0;
        else if (ang_red < HALF_TURN)
            quad = QT_90;
        else if (ang_red < THREE_QUARTER_TURN)
            quad = QT_180;
        else
            quad = QT_270;

        in_x = $signed({s_tdata[31], s_tdata[31:0]});
        in_y = $signed({s_tdata[63], s_tdata[63:32]});

        unique case (quad)
            QT_0:
            begin
                ang_off = '0;
                qx_next = in_x;
                qy_next = in_y;
            end
            QT_90:
            begin
                ang_off = QUARTER_TURN;
                qx_next = in_y;
                qy_next = -in_x;
            end
            QT_180:
            begin
                ang_off = HALF_TURN;
                qx_next = -in_x;
                qy_next = -in_y;
            end
            QT_270:
            begin
                ang_off = THREE_QUARTER_TURN;
                qx_next = -in_y;
                qy_next = in_x;
            end
            default:
            begin
                ang_off = '0;
                qx_next = in_x;
                qy_next = in_y;
            end
        endcase
        rem_full = ang_red - ang_off;
    end

    always_ff @(posedge clk)
    begin
        if (rdy[0] && s_tvalid)
        begin
            qx_reg  <= qx_next;
            qy_reg  <= qy_next;
            rem_reg <= rem_full[REM_W-1:0];
        end
    end

    // Gain compensation and the two halves of the degree-to-radian product.
    assign px       = qx_reg * $signed({1'b0, GAIN_Q32});
    assign py       = qy_reg * $signed({1'b0, GAIN_Q32});
    assign zhi_next = rem_reg * RAD_HI;
    assign zlo_next = rem_reg * RAD_LO;

    always_ff @(posedge clk)
    begin
        if (rdy[1] && vld_reg[0])
        begin
            gx_reg  <= px[63:16];
            gy_reg  <= py[63:16];
            zhi_reg <= zhi_next;
            zlo_reg <= zlo_next;
        end
    end

    // Radian angle assembled; vector widened for growth through the rotations.
    always_ff @(posedge clk)
    begin
        if (rdy[2] && vld_reg[1])
        begin
            cx_reg[0] <= $signed({{(XW-GX_W){gx_reg[GX_W-1]}}, gx_reg});
            cy_reg[0] <= $signed({{(XW-GX_W){gy_reg[GX_W-1]}}, gy_reg});
            cz_reg[0] <= $signed({zhi_reg, {RAD_LO_W{1'b0}}})
                       + $signed({{(ZW-REM_W-RAD_LO_W){1'b0}}, zlo_reg});
        end
    end

    // One micro-rotation per stage, steered by the sign of the residual angle.
    for (genvar i = 0; i < CORDIC_STAGES; i++)
    begin : g_stage
        localparam logic [63:0] ATAN_I = atan_q60(i);
        localparam logic signed [ZW-1:0] ATAN_Z = ATAN_I[ZW-1:0];

        logic signed [XW-1:0] dx;
        logic signed [XW-1:0] dy;

        assign dx = cy_reg[i] >>> i;
        assign dy = cx_reg[i] >>> i;

        always_ff @(posedge clk)
        begin
            if (rdy[i+3] && vld_reg[i+2])
            begin
                if (!cz_reg[i][ZW-1])
                begin
                    cx_reg[i+1] <= cx_reg[i] + dx;
                    cy_reg[i+1] <= cy_reg[i] - dy;
                    cz_reg[i+1] <= cz_reg[i] - ATAN_Z;
                end
                else
                begin
                    cx_reg[i+1] <= cx_reg[i] - dx;
                    cy_reg[i+1] <= cy_reg[i] + dy;
                    cz_reg[i+1] <= cz_reg[i] + ATAN_Z;
                end
            end
        end
    end

    // Rounding and saturation into the output register.
    always_ff @(posedge clk)
    begin
        if (rdy[L-1] && vld_reg[L-2])
        begin
            rx_reg <= round_sat(cx_reg[CORDIC_STAGES]);
            ry_reg <= round_sat(cy_reg[CORDIC_STAGES]);
        end
    end

    // An accepted word always lands in the first stage.
    a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> vld_reg[0])
        else $error("accepted word did not enter the first stage");

    // Input is refused only when every stage holds a word.
    a_full_when_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> &vld_reg)
        else $error("input refused while a bubble sits in the pipeline");

    // The remainder after the quarter turn is below ninety degrees.
    a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[0] |-> rem_reg < QUARTER_TURN[REM_W-1:0] || rem_reg == '0)
        else $error("angle remainder out of range");

    // The radian angle entering the rotations is never negative.
    a_z_start: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[2] |-> !cz_reg[0][ZW-1])
        else $error("initial residual angle negative");

endmodule
